>>> hw/rtl/ppp_option_negotiation_fsm_core_assert.svh
// Assertion macros used by the checker of the PPP negotiation core.
`ifndef PPP_OPTION_NEGOTIATION_FSM_CORE_ASSERT_SVH
`define PPP_OPTION_NEGOTIATION_FSM_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge.
`define PPONF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge.
`define PPONF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/pponf_pkg.sv
// Types and codes of the PPP option negotiation core.
`timescale 1ns / 1ps
package pponf_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CONFIGURE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TERMINATE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_CONTROL  = 2'd2;

   localparam logic [7:0] MAX_CONFIGURE_RESET = 8'd10;
   localparam logic [7:0] MAX_TERMINATE_RESET = 8'd2;
   localparam logic       LINK_CONTROL_RESET  = 1'b1;

   localparam logic [3:0] OP_UP      = 4'd0;
   localparam logic [3:0] OP_DOWN    = 4'd1;
   localparam logic [3:0] OP_CLOSE   = 4'd2;
   localparam logic [3:0] OP_TIMEOUT = 4'd3;
   localparam logic [3:0] OP_CONFREQ = 4'd4;
   localparam logic [3:0] OP_CONFACK = 4'd5;
   localparam logic [3:0] OP_CONFNAK = 4'd6;
   localparam logic [3:0] OP_CONFREJ = 4'd7;
   localparam logic [3:0] OP_TERMREQ = 4'd8;
   localparam logic [3:0] OP_TERMACK = 4'd9;
   localparam logic [3:0] OP_CODEREJ = 4'd10;

   localparam logic [2:0] VD_OK        = 3'd0;
   localparam logic [2:0] VD_NAK       = 3'd1;
   localparam logic [2:0] VD_FATAL     = 3'd3;
   localparam logic [2:0] VD_MAGIC_NAK = 3'd4;

   localparam logic [3:0] CS_INITIAL  = 4'd0;
   localparam logic [3:0] CS_STARTING = 4'd1;
   localparam logic [3:0] CS_CLOSED   = 4'd2;
   localparam logic [3:0] CS_STOPPED  = 4'd3;
   localparam logic [3:0] CS_CLOSING  = 4'd4;
   localparam logic [3:0] CS_STOPPING = 4'd5;
   localparam logic [3:0] CS_REQSENT  = 4'd6;
   localparam logic [3:0] CS_ACKRCVD  = 4'd7;
   localparam logic [3:0] CS_ACKSENT  = 4'd8;
   localparam logic [3:0] CS_OPENED   = 4'd9;

   localparam logic [2:0] RC_NONE    = 3'd0;
   localparam logic [2:0] RC_CONFACK = 3'd1;
   localparam logic [2:0] RC_CONFNAK = 3'd2;
   localparam logic [2:0] RC_CONFREJ = 3'd3;
   localparam logic [2:0] RC_TERMACK = 3'd4;
   localparam logic [2:0] RC_CODEREJ = 3'd5;

   localparam logic [1:0] TM_KEEP  = 2'd0;
   localparam logic [1:0] TM_START = 2'd1;
   localparam logic [1:0] TM_STOP  = 2'd2;

   typedef struct packed {
      logic [3:0] opcode;
      logic [7:0] packet_id;
      logic [2:0] option_verdict;
      logic       prerequisites_met;
   } pponf_req_type;

   typedef struct packed {
      logic [3:0] new_state;
      logic [2:0] reply_code;
      logic [7:0] reply_id;
      logic       send_request;
      logic [7:0] request_number;
      logic       send_terminate;
      logic       layer_up;
      logic       layer_down;
      logic       layer_finished;
      logic [1:0] timer_command;
      logic       reset_tx_accm;
   } pponf_rsp_type;

endpackage

>>> hw/rtl/ppp_option_negotiation_fsm_core.sv
// PPP control-protocol automaton: one event in, one action set out.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  pponf_req_type
//   rsp_      out        rsp_valid/rsp_stall  pponf_rsp_type
//   csr_      in         csr_write            csr_index, csr_wdata
//
// The state table is evaluated in the cycle of the transfer and the result
// is registered before it is offered on the rsp_ channel.
// One event per cycle is sustained while the result side keeps up.
// A two-entry output (result register plus skid register) absorbs one stall;
// req_stall rises only while the skid register is full.
// Synchronous reset returns the automaton to the initial state.
`timescale 1ns / 1ps
module ppp_option_negotiation_fsm_core
   import pponf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pponf_req_type          req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pponf_rsp_type          rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_INITIAL  = CS_INITIAL,
      S_STARTING = CS_STARTING,
      S_CLOSED   = CS_CLOSED,
      S_STOPPED  = CS_STOPPED,
      S_CLOSING  = CS_CLOSING,
      S_STOPPING = CS_STOPPING,
      S_REQSENT  = CS_REQSENT,
      S_ACKRCVD  = CS_ACKRCVD,
      S_ACKSENT  = CS_ACKSENT,
      S_OPENED   = CS_OPENED
   } state_type;

   state_type     state_ff, state_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    reqid_ff, reqid_in;
   logic [7:0]    max_configure_ff, max_configure_in;
   logic [7:0]    max_terminate_ff, max_terminate_in;
   logic          link_control_ff, link_control_in;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   pponf_rsp_type out_data_ff, out_data_in;
   pponf_rsp_type skid_data_ff, skid_data_in;

   pponf_rsp_type act;
   logic          req_take;
   logic          rsp_take;
   logic          packet_ok;
   logic          request_en;
   logic          close_en;
   logic          down_en;
   logic          accm_en;
   logic          confreq_done;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   assign packet_ok = (link_control_ff || req_data.prerequisites_met) &&
      !((state_ff == S_INITIAL || state_ff == S_STARTING) &&
        req_data.opcode != OP_TERMACK);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      reqid_in     = reqid_ff;
      act          = '0;
      request_en   = 1'b0;
      close_en     = 1'b0;
      down_en      = 1'b0;
      accm_en      = 1'b0;
      confreq_done = 1'b0;

      priority if (req_data.opcode == OP_UP) begin
         count_in   = max_configure_ff;
         state_in   = S_REQSENT;
         request_en = 1'b1;
      end else if (req_data.opcode == OP_DOWN) begin
         if (state_ff == S_CLOSING || state_ff == S_CLOSED) begin
            state_in = S_INITIAL;
         end else begin
            down_en  = (state_ff == S_OPENED);
            state_in = S_STARTING;
         end
         act.timer_command = TM_STOP;
      end else if (req_data.opcode == OP_CLOSE) begin
         close_en = 1'b1;
      end else if (req_data.opcode == OP_TIMEOUT) begin
         if (count_ff == 8'd1) begin
            count_in = 8'd0;
            state_in = (state_ff == S_CLOSING) ? S_CLOSED : S_STOPPED;
            act.layer_finished = 1'b1;
         end else begin
            if (count_ff != 8'd0) begin
               count_in = count_ff - 8'd1;
            end
            unique case (state_ff)
               S_CLOSING, S_STOPPING: begin
                  act.send_terminate = 1'b1;
                  act.timer_command  = TM_START;
               end
               S_ACKRCVD: begin
                  state_in   = S_REQSENT;
                  request_en = 1'b1;
               end
               S_REQSENT, S_ACKSENT: begin
                  request_en = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end else if (packet_ok) begin
         priority case (req_data.opcode)
            OP_CONFREQ: begin
               unique case (state_ff)
                  S_CLOSING, S_STOPPING: begin
                     confreq_done = 1'b1;
                  end
                  S_CLOSED: begin
                     act.reply_code = RC_TERMACK;
                     act.reply_id   = req_data.packet_id;
                     confreq_done   = 1'b1;
                  end
                  S_STOPPED: begin
                     count_in   = max_configure_ff;
                     accm_en    = 1'b1;
                     request_en = 1'b1;
                  end
                  S_OPENED: begin
                     down_en    = 1'b1;
                     accm_en    = 1'b1;
                     request_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (!confreq_done) begin
                  if (req_data.option_verdict == VD_FATAL) begin
                     close_en = 1'b1;
                  end else if (req_data.option_verdict == VD_OK) begin
                     act.reply_code = RC_CONFACK;
                     act.reply_id   = req_data.packet_id;
                     if (state_ff == S_ACKRCVD) begin
                        state_in     = S_OPENED;
                        act.layer_up = 1'b1;
                     end else begin
                        state_in = S_ACKSENT;
                     end
                  end else begin
                     act.reply_code = (req_data.option_verdict == VD_NAK ||
                                       req_data.option_verdict == VD_MAGIC_NAK) ?
                                      RC_CONFNAK : RC_CONFREJ;
                     act.reply_id   = req_data.packet_id;
                     if (state_ff != S_ACKRCVD) begin
                        state_in = S_REQSENT;
                     end
                  end
               end
            end
            OP_CONFACK: begin
               if (req_data.packet_id == reqid_ff) begin
                  act.timer_command = TM_STOP;
                  unique case (state_ff)
                     S_CLOSED, S_STOPPED: begin
                        act.reply_code = RC_TERMACK;
                        act.reply_id   = req_data.packet_id;
                     end
                     S_REQSENT: begin
                        state_in = S_ACKRCVD;
                        count_in = max_configure_ff;
                     end
                     S_OPENED, S_ACKRCVD: begin
                        down_en    = (state_ff == S_OPENED);
                        state_in   = S_REQSENT;
                        request_en = 1'b1;
                     end
                     S_ACKSENT: begin
                        state_in     = S_OPENED;
                        count_in     = max_configure_ff;
                        act.layer_up = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            OP_CONFNAK, OP_CONFREJ: begin
               if (req_data.packet_id == reqid_ff) begin
                  act.timer_command = TM_STOP;
                  unique case (state_ff)
                     S_CLOSED, S_STOPPED: begin
                        act.reply_code = RC_TERMACK;
                        act.reply_id   = req_data.packet_id;
                     end
                     S_REQSENT, S_ACKSENT: begin
                        count_in   = max_configure_ff;
                        request_en = 1'b1;
                     end
                     S_OPENED, S_ACKRCVD: begin
                        down_en    = (state_ff == S_OPENED);
                        state_in   = S_REQSENT;
                        request_en = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            OP_TERMREQ: begin
               unique case (state_ff)
                  S_OPENED: begin
                     count_in          = 8'd1;
                     down_en           = 1'b1;
                     state_in          = S_STOPPING;
                     act.timer_command = TM_START;
                  end
                  S_ACKRCVD, S_ACKSENT: begin
                     state_in = S_REQSENT;
                  end
                  default: begin
                  end
               endcase
               accm_en        = 1'b1;
               act.reply_code = RC_TERMACK;
               act.reply_id   = req_data.packet_id;
            end
            OP_TERMACK: begin
               act.timer_command = TM_STOP;
               unique case (state_ff)
                  S_OPENED: begin
                     down_en    = 1'b1;
                     state_in   = S_REQSENT;
                     request_en = 1'b1;
                  end
                  S_ACKRCVD: begin
                     state_in = S_REQSENT;
                  end
                  S_INITIAL, S_CLOSING: begin
                     state_in           = S_CLOSED;
                     act.layer_finished = 1'b1;
                  end
                  S_STOPPING: begin
                     state_in           = S_STOPPED;
                     act.layer_finished = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            OP_CODEREJ: begin
            end
            default: begin
               act.reply_code = RC_CODEREJ;
               act.reply_id   = 8'd0;
            end
         endcase
      end else begin
      end

      // A configure request never follows a close in the same event.
      if (request_en) begin
         reqid_in           = reqid_ff + 8'd1;
         act.send_request   = 1'b1;
         act.request_number = reqid_in;
         act.timer_command  = TM_START;
      end

      // The close event acts on the state left by the earlier actions.
      if (close_en) begin
         unique case (state_in)
            S_STARTING: state_in = S_INITIAL;
            S_STOPPED:  state_in = S_CLOSED;
            S_STOPPING: state_in = S_CLOSING;
            S_OPENED, S_REQSENT, S_ACKRCVD, S_ACKSENT: begin
               if (state_in == S_OPENED) begin
                  down_en = 1'b1;
               end
               count_in           = max_terminate_ff;
               state_in           = S_CLOSING;
               accm_en            = 1'b1;
               act.send_terminate = 1'b1;
               act.timer_command  = TM_START;
            end
            default: begin
            end
         endcase
      end

      act.layer_down    = down_en && link_control_ff;
      act.reset_tx_accm = accm_en && link_control_ff;
      act.new_state     = state_in;
   end

   always_comb begin
      max_configure_in = max_configure_ff;
      max_terminate_in = max_terminate_ff;
      link_control_in  = link_control_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_CONFIGURE: max_configure_in = csr_wdata;
            CSR_MAX_TERMINATE: max_terminate_in = csr_wdata;
            CSR_LINK_CONTROL:  link_control_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (req_take) begin
            out_data_in = act;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff) begin
            out_data_in  = act;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = act;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         state_ff         <= S_INITIAL;
         count_ff         <= 8'd0;
         reqid_ff         <= 8'd0;
         max_configure_ff <= MAX_CONFIGURE_RESET;
         max_terminate_ff <= MAX_TERMINATE_RESET;
         link_control_ff  <= LINK_CONTROL_RESET;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
            count_ff <= count_in;
            reqid_ff <= reqid_in;
         end
         max_configure_ff <= max_configure_in;
         max_terminate_ff <= max_terminate_in;
         link_control_ff  <= link_control_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

endmodule

>>> hw/rtl/pponf_checker.sv
// Port-level checker of the PPP negotiation core and its bind statement.
`timescale 1ns / 1ps
`include "ppp_option_negotiation_fsm_core_assert.svh"
module pponf_checker
   import pponf_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input pponf_rsp_type rsp_data
);

   `PPONF_ASSERT_NXT(a_reset_clears_valid, reset, !rsp_valid)
   `PPONF_ASSERT_NXT(a_stalled_result_holds, !reset && rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `PPONF_ASSERT_IMP(a_send_starts_timer, rsp_valid && (rsp_data.send_request || rsp_data.send_terminate), rsp_data.timer_command == TM_START)
   `PPONF_ASSERT_IMP(a_up_means_opened, rsp_valid && rsp_data.layer_up, rsp_data.new_state == CS_OPENED)

endmodule

bind ppp_option_negotiation_fsm_core pponf_checker u_pponf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> sim/tb_top.sv
// Self-checking testbench for the PPP option negotiation core.
`timescale 1ns / 1ps
module tb_top;
   import pponf_pkg::*;

   localparam logic [2:0] VD_REJECT       = 3'd2;
   localparam logic [2:0] VD_OUT_OF_RANGE = 3'd7;
   localparam logic [3:0] OP_UNKNOWN      = 4'd11;
   localparam logic [3:0] OP_LAST_CODE    = 4'd15;
   localparam int         WATCHDOG_CYCLES = 2000;
   localparam int         LONG_HOLD       = 48;

   typedef struct packed {
      logic [3:0] state;
      logic [7:0] restart;
      logic [7:0] req_id;
      logic [7:0] max_conf;
      logic [7:0] max_term;
      logic       link_ctl;
   } fsm_ctx_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   pponf_req_type          req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   pponf_rsp_type          rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   fsm_ctx_type   accepted_fsm;
   fsm_ctx_type   planned_fsm;
   pponf_req_type pending_events[$];
   pponf_rsp_type expected_actions[$];
   int            send_idle_pct = 31;
   int            recv_idle_pct = 31;
   int            hold_requests = 0;
   int            holds_served = 0;
   int            hold_left = 0;
   int            error_count = 0;
   int            rsp_count = 0;
   int            quiet_cycles = 0;

   ppp_option_negotiation_fsm_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 100) begin
         $display("mismatch at result %0d: %s got %0d, expected %0d", rsp_count, what, got, want);
      end
      error_count++;
   endtask

   task automatic send_conf_request(inout fsm_ctx_type ctx, inout pponf_rsp_type act);
      ctx.req_id = ctx.req_id + 8'd1;
      act.send_request = 1'b1;
      act.request_number = ctx.req_id;
      act.timer_command = TM_START;
   endtask

   task automatic start_close(inout fsm_ctx_type ctx, inout pponf_rsp_type act);
      case (ctx.state)
         CS_STARTING: ctx.state = CS_INITIAL;
         CS_STOPPED: ctx.state = CS_CLOSED;
         CS_STOPPING: ctx.state = CS_CLOSING;
         CS_OPENED, CS_REQSENT, CS_ACKRCVD, CS_ACKSENT: begin
            if (ctx.state == CS_OPENED && ctx.link_ctl) act.layer_down = 1'b1;
            ctx.restart = ctx.max_term;
            ctx.state = CS_CLOSING;
            if (ctx.link_ctl) act.reset_tx_accm = 1'b1;
            act.send_terminate = 1'b1;
            act.timer_command = TM_START;
         end
         default: ;
      endcase
   endtask

   task automatic negotiate(inout fsm_ctx_type ctx, input pponf_req_type ev,
                            output pponf_rsp_type act);
      logic [2:0] verdict;
      act = '0;
      verdict = ev.option_verdict;
      if (ev.opcode == OP_UP) begin
         ctx.restart = ctx.max_conf;
         ctx.state = CS_REQSENT;
         send_conf_request(ctx, act);
      end else if (ev.opcode == OP_DOWN) begin
         if (ctx.state == CS_CLOSING || ctx.state == CS_CLOSED) begin
            ctx.state = CS_INITIAL;
         end else begin
            if (ctx.state == CS_OPENED && ctx.link_ctl) act.layer_down = 1'b1;
            ctx.state = CS_STARTING;
         end
         act.timer_command = TM_STOP;
      end else if (ev.opcode == OP_CLOSE) begin
         start_close(ctx, act);
      end else if (ev.opcode == OP_TIMEOUT) begin
         if (ctx.restart == 8'd1) begin
            ctx.restart = 8'd0;
            ctx.state = (ctx.state == CS_CLOSING) ? CS_CLOSED : CS_STOPPED;
            act.layer_finished = 1'b1;
         end else begin
            if (ctx.restart != 8'd0) ctx.restart = ctx.restart - 8'd1;
            case (ctx.state)
               CS_CLOSING, CS_STOPPING: begin
                  act.send_terminate = 1'b1;
                  act.timer_command = TM_START;
               end
               CS_ACKRCVD, CS_REQSENT, CS_ACKSENT: begin
                  if (ctx.state == CS_ACKRCVD) ctx.state = CS_REQSENT;
                  send_conf_request(ctx, act);
               end
               default: ;
            endcase
         end
      end else if ((ctx.link_ctl || ev.prerequisites_met) &&
                   !((ctx.state == CS_INITIAL || ctx.state == CS_STARTING) &&
                     ev.opcode != OP_TERMACK)) begin
         case (ev.opcode)
            OP_CONFREQ: begin
               if (ctx.state == CS_CLOSED) begin
                  act.reply_code = RC_TERMACK;
                  act.reply_id = ev.packet_id;
               end else if (ctx.state != CS_CLOSING && ctx.state != CS_STOPPING) begin
                  if (ctx.state == CS_STOPPED || ctx.state == CS_OPENED) begin
                     if (ctx.state == CS_STOPPED) begin
                        ctx.restart = ctx.max_conf;
                     end else if (ctx.link_ctl) begin
                        act.layer_down = 1'b1;
                     end
                     if (ctx.link_ctl) act.reset_tx_accm = 1'b1;
                     send_conf_request(ctx, act);
                  end
                  if (verdict == VD_FATAL) begin
                     start_close(ctx, act);
                  end else if (verdict == VD_OK) begin
                     act.reply_code = RC_CONFACK;
                     act.reply_id = ev.packet_id;
                     if (ctx.state == CS_ACKRCVD) begin
                        ctx.state = CS_OPENED;
                        act.layer_up = 1'b1;
                     end else begin
                        ctx.state = CS_ACKSENT;
                     end
                  end else begin
                     act.reply_code = (verdict == VD_NAK || verdict == VD_MAGIC_NAK) ?
                                      RC_CONFNAK : RC_CONFREJ;
                     act.reply_id = ev.packet_id;
                     if (ctx.state != CS_ACKRCVD) ctx.state = CS_REQSENT;
                  end
               end
            end
            OP_CONFACK: begin
               if (ev.packet_id == ctx.req_id) begin
                  act.timer_command = TM_STOP;
                  case (ctx.state)
                     CS_CLOSED, CS_STOPPED: begin
                        act.reply_code = RC_TERMACK;
                        act.reply_id = ev.packet_id;
                     end
                     CS_REQSENT: begin
                        ctx.state = CS_ACKRCVD;
                        ctx.restart = ctx.max_conf;
                     end
                     CS_OPENED, CS_ACKRCVD: begin
                        if (ctx.state == CS_OPENED && ctx.link_ctl) act.layer_down = 1'b1;
                        ctx.state = CS_REQSENT;
                        send_conf_request(ctx, act);
                     end
                     CS_ACKSENT: begin
                        ctx.state = CS_OPENED;
                        ctx.restart = ctx.max_conf;
                        act.layer_up = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            OP_CONFNAK, OP_CONFREJ: begin
               if (ev.packet_id == ctx.req_id) begin
                  act.timer_command = TM_STOP;
                  case (ctx.state)
                     CS_CLOSED, CS_STOPPED: begin
                        act.reply_code = RC_TERMACK;
                        act.reply_id = ev.packet_id;
                     end
                     CS_REQSENT, CS_ACKSENT: begin
                        ctx.restart = ctx.max_conf;
                        send_conf_request(ctx, act);
                     end
                     CS_OPENED, CS_ACKRCVD: begin
                        if (ctx.state == CS_OPENED && ctx.link_ctl) act.layer_down = 1'b1;
                        ctx.state = CS_REQSENT;
                        send_conf_request(ctx, act);
                     end
                     default: ;
                  endcase
               end
            end
            OP_TERMREQ: begin
               case (ctx.state)
                  CS_OPENED: begin
                     ctx.restart = 8'd1;
                     if (ctx.link_ctl) act.layer_down = 1'b1;
                     ctx.state = CS_STOPPING;
                     act.timer_command = TM_START;
                  end
                  CS_ACKRCVD, CS_ACKSENT: ctx.state = CS_REQSENT;
                  default: ;
               endcase
               if (ctx.link_ctl) act.reset_tx_accm = 1'b1;
               act.reply_code = RC_TERMACK;
               act.reply_id = ev.packet_id;
            end
            OP_TERMACK: begin
               act.timer_command = TM_STOP;
               case (ctx.state)
                  CS_OPENED: begin
                     if (ctx.link_ctl) act.layer_down = 1'b1;
                     ctx.state = CS_REQSENT;
                     send_conf_request(ctx, act);
                  end
                  CS_ACKRCVD: ctx.state = CS_REQSENT;
                  CS_INITIAL, CS_CLOSING: begin
                     ctx.state = CS_CLOSED;
                     act.layer_finished = 1'b1;
                  end
                  CS_STOPPING: begin
                     ctx.state = CS_STOPPED;
                     act.layer_finished = 1'b1;
                  end
                  default: ;
               endcase
            end
            OP_CODEREJ: ;
            default: begin
               act.reply_code = RC_CODEREJ;
               act.reply_id = 8'd0;
            end
         endcase
      end
      act.new_state = ctx.state;
   endtask

   task automatic queue_event(input pponf_req_type ev);
      pponf_rsp_type ignored;
      pending_events.push_back(ev);
      negotiate(planned_fsm, ev, ignored);
   endtask

   task automatic queue_fields(input logic [3:0] op, input logic [7:0] id,
                               input logic [2:0] verdict, input logic prereq);
      pponf_req_type ev;
      ev.opcode = op;
      ev.packet_id = id;
      ev.option_verdict = verdict;
      ev.prerequisites_met = prereq;
      queue_event(ev);
   endtask

   task automatic queue_random_event();
      pponf_req_type ev;
      int roll;
      ev.packet_id = 8'($urandom_range(255));
      ev.option_verdict = ($urandom_range(1) != 0) ? VD_OK : 3'($urandom_range(7));
      ev.prerequisites_met = ($urandom_range(3) != 0);
      roll = $urandom_range(99);
      if (roll < 65) begin
         case (planned_fsm.state)
            CS_INITIAL, CS_STARTING: ev.opcode = (roll < 55) ? OP_UP : OP_TERMACK;
            CS_CLOSED, CS_STOPPED: ev.opcode = (roll < 35) ? OP_UP : OP_CONFREQ;
            CS_REQSENT: ev.opcode = (roll < 30) ? OP_CONFACK : OP_CONFREQ;
            CS_ACKRCVD: ev.opcode = (roll < 50) ? OP_CONFREQ : OP_TIMEOUT;
            CS_ACKSENT: ev.opcode = (roll < 40) ? OP_CONFACK : OP_CONFNAK;
            CS_OPENED: ev.opcode = 4'(OP_CLOSE + $urandom_range(7));
            default: ev.opcode = (roll < 45) ? OP_TIMEOUT : OP_TERMACK;
         endcase
         if (ev.opcode == OP_CONFACK || ev.opcode == OP_CONFNAK || ev.opcode == OP_CONFREJ) begin
            ev.packet_id = planned_fsm.req_id;
         end
      end else begin
         ev.opcode = 4'($urandom_range(15));
         if ($urandom_range(1) != 0) ev.packet_id = planned_fsm.req_id;
      end
      queue_event(ev);
   endtask

   task automatic apply_config(input logic [7:0] conf_load, input logic [7:0] term_load,
                               input logic link_ctl);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MAX_CONFIGURE;
      csr_wdata <= conf_load;
      @(posedge clock);
      csr_index <= CSR_MAX_TERMINATE;
      csr_wdata <= term_load;
      @(posedge clock);
      csr_index <= CSR_LINK_CONTROL;
      csr_wdata <= CSR_DATA_W'(link_ctl);
      @(posedge clock);
      csr_write <= 1'b0;
      accepted_fsm.max_conf = conf_load;
      accepted_fsm.max_term = term_load;
      accepted_fsm.link_ctl = link_ctl;
      planned_fsm = accepted_fsm;
   endtask

   task automatic wait_until_drained();
      while (pending_events.size() != 0 || req_valid || expected_actions.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : event_driver
      pponf_rsp_type act;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            negotiate(accepted_fsm, req_data, act);
            expected_actions.push_back(act);
         end
         if (!req_valid || !req_stall) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_events.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      pponf_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_actions.size() == 0) begin
               report_mismatch("unexpected result transfer", 1, 0);
            end else begin
               want = expected_actions.pop_front();
               if (rsp_data.new_state != want.new_state)
                  report_mismatch("new_state", rsp_data.new_state, want.new_state);
               if (rsp_data.reply_code != want.reply_code)
                  report_mismatch("reply_code", rsp_data.reply_code, want.reply_code);
               if (rsp_data.reply_id != want.reply_id)
                  report_mismatch("reply_id", rsp_data.reply_id, want.reply_id);
               if (rsp_data.send_request != want.send_request)
                  report_mismatch("send_request", rsp_data.send_request, want.send_request);
               if (rsp_data.request_number != want.request_number)
                  report_mismatch("request_number", rsp_data.request_number,
                                  want.request_number);
               if (rsp_data.send_terminate != want.send_terminate)
                  report_mismatch("send_terminate", rsp_data.send_terminate,
                                  want.send_terminate);
               if (rsp_data.layer_up != want.layer_up)
                  report_mismatch("layer_up", rsp_data.layer_up, want.layer_up);
               if (rsp_data.layer_down != want.layer_down)
                  report_mismatch("layer_down", rsp_data.layer_down, want.layer_down);
               if (rsp_data.layer_finished != want.layer_finished)
                  report_mismatch("layer_finished", rsp_data.layer_finished,
                                  want.layer_finished);
               if (rsp_data.timer_command != want.timer_command)
                  report_mismatch("timer_command", rsp_data.timer_command, want.timer_command);
               if (rsp_data.reset_tx_accm != want.reset_tx_accm)
                  report_mismatch("reset_tx_accm", rsp_data.reset_tx_accm, want.reset_tx_accm);
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      accepted_fsm = '0;
      accepted_fsm.max_conf = MAX_CONFIGURE_RESET;
      accepted_fsm.max_term = MAX_TERMINATE_RESET;
      accepted_fsm.link_ctl = LINK_CONTROL_RESET;
      accepted_fsm.state = CS_INITIAL;
      planned_fsm = accepted_fsm;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      queue_fields(OP_TERMACK, 8'hff, VD_OK, 1'b0);
      queue_fields(OP_CONFREQ, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_LAST_CODE, 8'hff, VD_OUT_OF_RANGE, 1'b1);
      queue_fields(OP_CODEREJ, 8'h5a, VD_OK, 1'b0);
      queue_fields(OP_UP, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_CONFNAK, planned_fsm.req_id + 8'd1, VD_OK, 1'b1);
      queue_fields(OP_CONFREQ, 8'h80, VD_OUT_OF_RANGE, 1'b1);
      queue_fields(OP_CONFREJ, planned_fsm.req_id, VD_REJECT, 1'b1);
      queue_fields(OP_CONFREQ, 8'h01, VD_MAGIC_NAK, 1'b1);
      queue_fields(OP_CONFACK, planned_fsm.req_id, VD_OK, 1'b1);
      queue_fields(OP_CONFREQ, 8'h7f, VD_OK, 1'b1);
      queue_fields(OP_TERMACK, 8'h10, VD_OK, 1'b1);
      queue_fields(OP_CONFREQ, 8'h11, VD_OK, 1'b1);
      queue_fields(OP_CONFACK, planned_fsm.req_id, VD_OK, 1'b1);
      queue_fields(OP_TERMREQ, 8'hab, VD_OK, 1'b1);
      queue_fields(OP_TIMEOUT, 8'h00, VD_OK, 1'b0);
      queue_fields(OP_CONFREQ, 8'h33, VD_FATAL, 1'b1);
      queue_fields(OP_UP, 8'hff, VD_OUT_OF_RANGE, 1'b0);
      queue_fields(OP_CLOSE, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_TIMEOUT, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_TIMEOUT, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_TIMEOUT, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_DOWN, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_CONFREQ, 8'h44, VD_OK, 1'b1);
      queue_fields(OP_UP, 8'h00, VD_OK, 1'b1);
      queue_fields(OP_CONFREQ, 8'h00, VD_NAK, 1'b1);
      queue_fields(OP_UNKNOWN, 8'h00, VD_OK, 1'b1);
      repeat (240) queue_random_event();
      wait_until_drained();

      apply_config(8'd1, 8'd1, 1'b1);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      repeat (300) queue_random_event();
      wait_until_drained();
      send_idle_pct <= 31;
      recv_idle_pct <= 31;

      apply_config(8'd255, 8'd255, 1'b0);
      repeat (250) queue_random_event();
      wait_until_drained();

      // The result side holds off for a long stretch while events keep coming.
      apply_config(8'd3, 8'd2, 1'b0);
      send_idle_pct <= 0;
      hold_requests <= hold_requests + 1;
      repeat (250) queue_random_event();
      wait_until_drained();
      send_idle_pct <= 31;

      apply_config(8'd2, 8'd3, 1'b1);
      repeat (400) queue_random_event();
      while (pending_events.size() != 0 || req_valid) @(posedge clock);
      for (int n = 0; n < 300 && expected_actions.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (expected_actions.size() != 0) begin
         report_mismatch("delivered results", 0, expected_actions.size());
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pponf_pkg.sv
hw/rtl/ppp_option_negotiation_fsm_core.sv
hw/rtl/pponf_checker.sv
sim/tb_top.sv
